/* src/adam_pkg.sv */
// Shared types and constants for the Adam update core.
package adam_pkg;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  typedef enum logic [2:0] {
    FOP_MUL  = 3'd0,
    FOP_ADD  = 3'd1,
    FOP_SUB  = 3'd2,
    FOP_DIV  = 3'd3,
    FOP_SQRT = 3'd4
  } fop_t;

  typedef struct packed {
    logic        valid;
    fop_t        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

endpackage

/* src/adam_optimizer_update_core.sv */
// Adam update core: sequencer over one shared iterative fp32 unit.
// Each element runs the Adam step list on the shared unit; subnormal operands take extra
// normalization shifts, and special operands skip the arithmetic and go straight to done.
// Only one element is in flight: not ready until the result is taken. An out-of-range
// index answers in the cycle after accept, or after the power updates with a pass start.
// Sync reset: state, config, power and valid regs to defaults.
module adam_optimizer_update_core #(
  parameter int NUM_ELEMENTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // elem_index[6:0], gradient[38:7], param_value[70:39]
  input  logic        in_tuser,   // pass_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_index[6:0], new_param[38:7]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MEM_DEPTH = (NUM_ELEMENTS < 128) ? NUM_ELEMENTS : 128;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [1:0] REG_LR  = 2'd0;
  localparam logic [1:0] REG_B1  = 2'd1;
  localparam logic [1:0] REG_B2  = 2'd2;
  localparam logic [1:0] REG_EPS = 2'd3;

  localparam logic [4:0] STEP_POW1 = 5'd0;
  localparam logic [4:0] STEP_POW2 = 5'd1;
  localparam logic [4:0] STEP_MOM  = 5'd2;
  localparam logic [4:0] STEP_VUPD = 5'd10;
  localparam logic [4:0] STEP_LAST = 5'd19;

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_LOAD  = 5'b00010,
    T_ISSUE = 5'b00100,
    T_WAIT  = 5'b01000,
    T_OUT   = 5'b10000
  } tstate_t;

  typedef enum logic [3:0] {
    SRC_ONE, SRC_B1, SRC_B2, SRC_LR, SRC_EPS, SRC_P1, SRC_P2,
    SRC_G, SRC_P, SRC_M, SRC_V, SRC_T1, SRC_T2
  } src_t;

  typedef enum logic [2:0] {
    DST_P1, DST_P2, DST_M, DST_V, DST_T1, DST_T2, DST_P
  } dst_t;

  typedef struct packed {
    adam_pkg::fop_t op;
    src_t           a;
    src_t           b;
    dst_t           d;
  } uop_t;

  function automatic uop_t uop_at(logic [4:0] step);
    uop_t u;
    u = '{adam_pkg::FOP_MUL, SRC_P1, SRC_B1, DST_P1};
    case (step)
      5'd0:  u = '{adam_pkg::FOP_MUL,  SRC_P1,  SRC_B1,  DST_P1};
      5'd1:  u = '{adam_pkg::FOP_MUL,  SRC_P2,  SRC_B2,  DST_P2};
      5'd2:  u = '{adam_pkg::FOP_MUL,  SRC_B1,  SRC_M,   DST_T1};
      5'd3:  u = '{adam_pkg::FOP_SUB,  SRC_ONE, SRC_B1,  DST_T2};
      5'd4:  u = '{adam_pkg::FOP_MUL,  SRC_T2,  SRC_G,   DST_T2};
      5'd5:  u = '{adam_pkg::FOP_ADD,  SRC_T1,  SRC_T2,  DST_M};
      5'd6:  u = '{adam_pkg::FOP_MUL,  SRC_B2,  SRC_V,   DST_T1};
      5'd7:  u = '{adam_pkg::FOP_SUB,  SRC_ONE, SRC_B2,  DST_T2};
      5'd8:  u = '{adam_pkg::FOP_MUL,  SRC_T2,  SRC_G,   DST_T2};
      5'd9:  u = '{adam_pkg::FOP_MUL,  SRC_T2,  SRC_G,   DST_T2};
      5'd10: u = '{adam_pkg::FOP_ADD,  SRC_T1,  SRC_T2,  DST_V};
      5'd11: u = '{adam_pkg::FOP_SUB,  SRC_ONE, SRC_P1,  DST_T1};
      5'd12: u = '{adam_pkg::FOP_DIV,  SRC_M,   SRC_T1,  DST_M};
      5'd13: u = '{adam_pkg::FOP_SUB,  SRC_ONE, SRC_P2,  DST_T1};
      5'd14: u = '{adam_pkg::FOP_DIV,  SRC_V,   SRC_T1,  DST_V};
      5'd15: u = '{adam_pkg::FOP_SQRT, SRC_V,   SRC_ONE, DST_V};
      5'd16: u = '{adam_pkg::FOP_ADD,  SRC_V,   SRC_EPS, DST_V};
      5'd17: u = '{adam_pkg::FOP_MUL,  SRC_LR,  SRC_M,   DST_M};
      5'd18: u = '{adam_pkg::FOP_DIV,  SRC_M,   SRC_V,   DST_M};
      5'd19: u = '{adam_pkg::FOP_SUB,  SRC_P,   SRC_M,   DST_P};
      default: u = '{adam_pkg::FOP_MUL, SRC_P1, SRC_B1, DST_P1};
    endcase
    return u;
  endfunction

  function automatic logic [31:0] canon(logic [31:0] x);
    if ((x[30:23] == 8'hFF) && (x[22:0] != 23'd0)) return adam_pkg::FP_QNAN;
    return x;
  endfunction

  function automatic logic in_rng(logic [6:0] idx);
    return ({25'd0, idx} < 32'(MEM_DEPTH));
  endfunction

  tstate_t     state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [31:0] lr_r, b1_r, b2_r, eps_r;
  logic [31:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [31:0] g_r, g_nxt, p_r, p_nxt, m_r, m_nxt, v_r, v_nxt;
  logic [31:0] t1_r, t1_nxt, t2_r, t2_nxt, outp_r, outp_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [MEM_DEPTH-1:0] vld_r;
  logic [63:0] mem [MEM_DEPTH];
  logic [63:0] rd_data_r;
  logic        rd_vld_r;
  logic        mem_we;

  adam_pkg::fpu_req_t req;
  adam_pkg::fpu_rsp_t rsp;
  uop_t               uop;
  logic               in_acc, cfg_wr;

  assign in_acc     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == T_IDLE);
  assign out_tvalid = (state_r == T_OUT);
  assign out_tdata  = {1'b0, outp_r, idx_r};
  assign uop        = uop_at(step_r);

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LR:  cfg_prdata = lr_r;
      REG_B1:  cfg_prdata = b1_r;
      REG_B2:  cfg_prdata = b2_r;
      REG_EPS: cfg_prdata = eps_r;
      default: cfg_prdata = lr_r;
    endcase
  end

  function automatic logic [31:0] pick(src_t s, logic [31:0] b1, logic [31:0] b2,
                                       logic [31:0] lr, logic [31:0] eps,
                                       logic [31:0] p1, logic [31:0] p2,
                                       logic [31:0] g, logic [31:0] p,
                                       logic [31:0] m, logic [31:0] v,
                                       logic [31:0] t1, logic [31:0] t2);
    case (s)
      SRC_ONE: return adam_pkg::FP_ONE;
      SRC_B1:  return b1;
      SRC_B2:  return b2;
      SRC_LR:  return lr;
      SRC_EPS: return eps;
      SRC_P1:  return p1;
      SRC_P2:  return p2;
      SRC_G:   return g;
      SRC_P:   return p;
      SRC_M:   return m;
      SRC_V:   return v;
      SRC_T1:  return t1;
      SRC_T2:  return t2;
      default: return adam_pkg::FP_ONE;
    endcase
  endfunction

  always_comb begin
    req.valid = (state_r == T_ISSUE);
    req.op    = uop.op;
    req.a     = pick(uop.a, b1_r, b2_r, lr_r, eps_r, p1_r, p2_r, g_r, p_r, m_r, v_r,
                     t1_r, t2_r);
    req.b     = pick(uop.b, b1_r, b2_r, lr_r, eps_r, p1_r, p2_r, g_r, p_r, m_r, v_r,
                     t1_r, t2_r);
  end

  always_comb begin
    state_nxt = state_r; step_nxt = step_r;
    p1_nxt = p1_r; p2_nxt = p2_r; g_nxt = g_r; p_nxt = p_r;
    m_nxt = m_r; v_nxt = v_r; t1_nxt = t1_r; t2_nxt = t2_r;
    outp_nxt = outp_r; idx_nxt = idx_r;
    mem_we = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          idx_nxt = in_tdata[6:0];
          g_nxt   = in_tdata[38:7];
          p_nxt   = in_tdata[70:39];
          if (in_tuser) begin
            step_nxt  = STEP_POW1;
            state_nxt = T_LOAD;
          end else if (in_rng(in_tdata[6:0])) begin
            step_nxt  = STEP_MOM;
            state_nxt = T_LOAD;
          end else begin
            outp_nxt  = canon(in_tdata[70:39]);
            state_nxt = T_OUT;
          end
        end
      end
      T_LOAD: begin
        m_nxt     = rd_vld_r ? rd_data_r[63:32] : 32'd0;
        v_nxt     = rd_vld_r ? rd_data_r[31:0]  : 32'd0;
        state_nxt = T_ISSUE;
      end
      T_ISSUE: state_nxt = T_WAIT;
      T_WAIT: begin
        if (rsp.done) begin
          case (uop.d)
            DST_P1:  p1_nxt = rsp.res;
            DST_P2:  p2_nxt = rsp.res;
            DST_M:   m_nxt  = rsp.res;
            DST_V:   v_nxt  = rsp.res;
            DST_T1:  t1_nxt = rsp.res;
            DST_T2:  t2_nxt = rsp.res;
            DST_P:   p_nxt  = rsp.res;
            default: t1_nxt = rsp.res;
          endcase
          mem_we = (step_r == STEP_VUPD);
          if (step_r == STEP_LAST) begin
            outp_nxt  = canon(rsp.res);
            state_nxt = T_OUT;
          end else if ((step_r == STEP_POW2) && !in_rng(idx_r)) begin
            outp_nxt  = canon(p_r);
            state_nxt = T_OUT;
          end else begin
            step_nxt  = step_r + 5'd1;
            state_nxt = T_ISSUE;
          end
        end
      end
      T_OUT: if (out_tready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      lr_r    <= 32'h3A83_126F;
      b1_r    <= 32'h3F66_6666;
      b2_r    <= 32'h3F7F_BE77;
      eps_r   <= 32'h322B_CC77;
      p1_r    <= adam_pkg::FP_ONE;
      p2_r    <= adam_pkg::FP_ONE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_LR:  lr_r  <= cfg_pwdata;
          REG_B1:  b1_r  <= cfg_pwdata;
          REG_B2:  b2_r  <= cfg_pwdata;
          REG_EPS: eps_r <= cfg_pwdata;
          default: lr_r  <= lr_r;
        endcase
      end
      if (mem_we) vld_r[idx_r[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    g_r    <= g_nxt;
    p_r    <= p_nxt;
    m_r    <= m_nxt;
    v_r    <= v_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    outp_r <= outp_nxt;
    idx_r  <= idx_nxt;
  end

  // moment store: {m, v} per element
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r[AW-1:0]] <= {m_r, rsp.res};
    if (in_acc) begin
      rd_data_r <= mem[in_tdata[AW-1:0]];
      rd_vld_r  <= vld_r[in_tdata[AW-1:0]];
    end
  end

  adam_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output both open");
  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !rsp.busy)
    else $error("fp request while unit busy");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == T_WAIT))
    else $error("fp result outside wait state");
  a_acc_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second transaction taken while busy");
`endif

endmodule

/* src/adam_fpu.sv */
// Iterative fp32 unit: multiply, add, subtract, divide and square root, RNE.
module adam_fpu (
  input  logic                clk,
  input  logic                rst_n,
  input  adam_pkg::fpu_req_t  req,
  output adam_pkg::fpu_rsp_t  rsp
);

  typedef logic signed [10:0] fexp_t;

  typedef enum logic [7:0] {
    F_IDLE   = 8'b0000_0001,
    F_NORM   = 8'b0000_0010,
    F_PREP   = 8'b0000_0100,
    F_CALC   = 8'b0000_1000,
    F_NRM_R  = 8'b0001_0000,
    F_DENORM = 8'b0010_0000,
    F_ROUND  = 8'b0100_0000,
    F_DONE   = 8'b1000_0000
  } fstate_t;

  fstate_t        state_r, state_nxt;
  adam_pkg::fop_t op_r, op_nxt;
  logic           sa_r, sa_nxt, sb_r, sb_nxt, rs_r, rs_nxt, sub_r, sub_nxt;
  fexp_t          ea_r, ea_nxt, eb_r, eb_nxt, rexp_r, rexp_nxt;
  logic [23:0]    ma_r, ma_nxt, mb_r, mb_nxt;
  logic [26:0]    mnt_r, mnt_nxt, aux_r, aux_nxt;
  logic [25:0]    rem_r, rem_nxt;
  logic [51:0]    rad_r, rad_nxt;
  logic [25:0]    root_r, root_nxt;
  logic [28:0]    srem_r, srem_nxt;
  logic [4:0]     cnt_r, cnt_nxt;
  logic [31:0]    res_r, res_nxt;

  // operand classification
  logic [31:0] bf;
  logic [7:0]  a_ex, b_ex;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
  logic        spec;
  logic [31:0] spec_res;

  always_comb begin
    bf     = (req.op == adam_pkg::FOP_SUB) ? {~req.b[31], req.b[30:0]} : req.b;
    a_ex   = req.a[30:23];
    b_ex   = bf[30:23];
    a_nan  = (a_ex == 8'hFF) && (req.a[22:0] != 23'd0);
    b_nan  = (b_ex == 8'hFF) && (bf[22:0] != 23'd0);
    a_inf  = (a_ex == 8'hFF) && (req.a[22:0] == 23'd0);
    b_inf  = (b_ex == 8'hFF) && (bf[22:0] == 23'd0);
    a_zero = (req.a[30:0] == 31'd0);
    b_zero = (bf[30:0] == 31'd0);
    sx     = req.a[31] ^ bf[31];
    spec     = 1'b0;
    spec_res = adam_pkg::FP_QNAN;
    case (req.op)
      adam_pkg::FOP_MUL: begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
          spec = 1'b1;
        end else if (a_inf || b_inf) begin
          spec = 1'b1; spec_res = {sx, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
          spec = 1'b1; spec_res = {sx, 31'd0};
        end
      end
      adam_pkg::FOP_ADD, adam_pkg::FOP_SUB: begin
        if (a_nan || b_nan || (a_inf && b_inf && sx)) begin
          spec = 1'b1;
        end else if (a_inf) begin
          spec = 1'b1; spec_res = req.a;
        end else if (b_inf) begin
          spec = 1'b1; spec_res = bf;
        end else if (a_zero && b_zero) begin
          spec = 1'b1; spec_res = {req.a[31] & bf[31], 31'd0};
        end else if (a_zero) begin
          spec = 1'b1; spec_res = bf;
        end else if (b_zero) begin
          spec = 1'b1; spec_res = req.a;
        end
      end
      adam_pkg::FOP_DIV: begin
        if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf)) begin
          spec = 1'b1;
        end else if (a_inf || b_zero) begin
          spec = 1'b1; spec_res = {sx, 8'hFF, 23'd0};
        end else if (a_zero || b_inf) begin
          spec = 1'b1; spec_res = {sx, 31'd0};
        end
      end
      adam_pkg::FOP_SQRT: begin
        if (a_nan) begin
          spec = 1'b1;
        end else if (a_zero) begin
          spec = 1'b1; spec_res = req.a;
        end else if (req.a[31]) begin
          spec = 1'b1;
        end else if (a_inf) begin
          spec = 1'b1; spec_res = req.a;
        end
      end
      default: spec = 1'b0;
    endcase
  end

  logic [47:0] prod;
  logic        a_big, qb, ge, inc;
  fexp_t       dexp;
  logic [53:0] shw;
  logic [23:0] m_big, m_sml;
  logic [26:0] diff;
  logic [27:0] sum28;
  logic [25:0] remsub;
  logic [28:0] cur, trial, sremsub;
  logic [24:0] rsum;
  fexp_t       bexp;

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; sa_nxt = sa_r; sb_nxt = sb_r;
    rs_nxt = rs_r; sub_nxt = sub_r; ea_nxt = ea_r; eb_nxt = eb_r;
    rexp_nxt = rexp_r; ma_nxt = ma_r; mb_nxt = mb_r; mnt_nxt = mnt_r;
    aux_nxt = aux_r; rem_nxt = rem_r; rad_nxt = rad_r; root_nxt = root_r;
    srem_nxt = srem_r; cnt_nxt = cnt_r; res_nxt = res_r;
    prod    = ma_r * mb_r;
    a_big   = (ea_r > eb_r) || ((ea_r == eb_r) && (ma_r >= mb_r));
    dexp    = a_big ? (ea_r - eb_r) : (eb_r - ea_r);
    m_big   = a_big ? ma_r : mb_r;
    m_sml   = a_big ? mb_r : ma_r;
    shw     = {m_sml, 30'd0} >> dexp[4:0];
    diff    = mnt_r - aux_r;
    sum28   = {1'b0, mnt_r} + {1'b0, aux_r};
    qb      = (rem_r >= {2'b00, mb_r});
    remsub  = qb ? (rem_r - {2'b00, mb_r}) : rem_r;
    cur     = {srem_r[26:0], rad_r[51:50]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = (cur >= trial);
    sremsub = ge ? (cur - trial) : cur;
    inc     = mnt_r[2] & ((|mnt_r[1:0]) | mnt_r[3]);
    rsum    = {1'b0, mnt_r[26:3]} + {24'd0, inc};
    bexp    = 11'sd0;

    case (state_r)
      F_IDLE: begin
        if (req.valid) begin
          if (spec) begin
            res_nxt   = spec_res;
            state_nxt = F_DONE;
          end else begin
            op_nxt = req.op;
            sa_nxt = req.a[31];
            sb_nxt = bf[31];
            ea_nxt = (a_ex == 8'd0) ? -11'sd126 : ($signed({3'b000, a_ex}) - 11'sd127);
            eb_nxt = (b_ex == 8'd0) ? -11'sd126 : ($signed({3'b000, b_ex}) - 11'sd127);
            ma_nxt = {a_ex != 8'd0, req.a[22:0]};
            mb_nxt = (req.op == adam_pkg::FOP_SQRT) ? 24'h80_0000 :
                     {b_ex != 8'd0, bf[22:0]};
            state_nxt = F_NORM;
          end
        end
      end
      F_NORM: begin
        // subnormal inputs: one bit per cycle
        if (!ma_r[23]) begin
          ma_nxt = {ma_r[22:0], 1'b0};
          ea_nxt = ea_r - 11'sd1;
        end
        if (!mb_r[23]) begin
          mb_nxt = {mb_r[22:0], 1'b0};
          eb_nxt = eb_r - 11'sd1;
        end
        if (ma_r[23] && mb_r[23]) state_nxt = F_PREP;
      end
      F_PREP: begin
        case (op_r)
          adam_pkg::FOP_MUL: begin
            mnt_nxt   = {prod[47:22], |prod[21:0]};
            rexp_nxt  = ea_r + eb_r + 11'sd1;
            rs_nxt    = sa_r ^ sb_r;
            state_nxt = F_NRM_R;
          end
          adam_pkg::FOP_ADD, adam_pkg::FOP_SUB: begin
            mnt_nxt = {m_big, 3'b000};
            if (dexp >= 11'sd27) aux_nxt = 27'd1;
            else aux_nxt = {shw[53:28], shw[27] | (|shw[26:0])};
            rexp_nxt  = a_big ? ea_r : eb_r;
            rs_nxt    = a_big ? sa_r : sb_r;
            sub_nxt   = sa_r ^ sb_r;
            state_nxt = F_CALC;
          end
          adam_pkg::FOP_DIV: begin
            rem_nxt   = {2'b00, ma_r};
            mnt_nxt   = 27'd0;
            cnt_nxt   = 5'd0;
            rexp_nxt  = ea_r - eb_r;
            rs_nxt    = sa_r ^ sb_r;
            state_nxt = F_CALC;
          end
          default: begin
            // root of an even-exponent radicand in [2^50, 2^52)
            rad_nxt   = ea_r[0] ? {ma_r, 28'd0} : {1'b0, ma_r, 27'd0};
            root_nxt  = 26'd0;
            srem_nxt  = 29'd0;
            cnt_nxt   = 5'd0;
            rexp_nxt  = ea_r >>> 1;
            rs_nxt    = 1'b0;
            state_nxt = F_CALC;
          end
        endcase
      end
      F_CALC: begin
        case (op_r)
          adam_pkg::FOP_ADD, adam_pkg::FOP_SUB: begin
            if (sub_r) begin
              mnt_nxt = diff;
              if (diff == 27'd0) rs_nxt = 1'b0;
            end else if (sum28[27]) begin
              mnt_nxt  = {sum28[27:2], sum28[1] | sum28[0]};
              rexp_nxt = rexp_r + 11'sd1;
            end else begin
              mnt_nxt = sum28[26:0];
            end
            state_nxt = F_NRM_R;
          end
          adam_pkg::FOP_DIV: begin
            rem_nxt = {remsub[24:0], 1'b0};
            cnt_nxt = cnt_r + 5'd1;
            if (cnt_r == 5'd26) begin
              mnt_nxt   = {mnt_r[25:0], qb | (remsub != 26'd0)};
              state_nxt = F_NRM_R;
            end else begin
              mnt_nxt = {mnt_r[25:0], qb};
            end
          end
          default: begin
            srem_nxt = sremsub;
            root_nxt = {root_r[24:0], ge};
            rad_nxt  = {rad_r[49:0], 2'b00};
            cnt_nxt  = cnt_r + 5'd1;
            if (cnt_r == 5'd25) begin
              mnt_nxt   = {root_r[24:0], ge, sremsub != 29'd0};
              state_nxt = F_NRM_R;
            end
          end
        endcase
      end
      F_NRM_R: begin
        if ((mnt_r != 27'd0) && !mnt_r[26]) begin
          mnt_nxt  = {mnt_r[25:0], 1'b0};
          rexp_nxt = rexp_r - 11'sd1;
        end else begin
          state_nxt = F_DENORM;
        end
      end
      F_DENORM: begin
        if (rexp_r < -11'sd153) begin
          mnt_nxt  = {26'd0, |mnt_r};
          rexp_nxt = -11'sd126;
        end else if (rexp_r < -11'sd126) begin
          mnt_nxt  = {1'b0, mnt_r[26:2], mnt_r[1] | mnt_r[0]};
          rexp_nxt = rexp_r + 11'sd1;
        end else begin
          state_nxt = F_ROUND;
        end
      end
      F_ROUND: begin
        if (rsum[24]) bexp = rexp_r + 11'sd128;
        else if (rsum[23]) bexp = rexp_r + 11'sd127;
        else bexp = 11'sd0;
        if (bexp >= 11'sd255) res_nxt = {rs_r, 8'hFF, 23'd0};
        else if (rsum[24]) res_nxt = {rs_r, bexp[7:0], 23'd0};
        else res_nxt = {rs_r, bexp[7:0], rsum[22:0]};
        state_nxt = F_DONE;
      end
      F_DONE: state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;   sa_r   <= sa_nxt;   sb_r <= sb_nxt;
    rs_r   <= rs_nxt;   sub_r  <= sub_nxt;  ea_r <= ea_nxt;
    eb_r   <= eb_nxt;   rexp_r <= rexp_nxt; ma_r <= ma_nxt;
    mb_r   <= mb_nxt;   mnt_r  <= mnt_nxt;  aux_r <= aux_nxt;
    rem_r  <= rem_nxt;  rad_r  <= rad_nxt;  root_r <= root_nxt;
    srem_r <= srem_nxt; cnt_r  <= cnt_nxt;  res_r <= res_nxt;
  end

  assign rsp.busy = (state_r != F_IDLE);
  assign rsp.done = (state_r == F_DONE);
  assign rsp.res  = res_r;

endmodule
